// File: rtl/core/fde_pkg.sv
package fde_pkg;

  // Line geometry
  localparam int LINE_DEPTH = 131072;
  localparam int CHANNELS   = 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_AW     = CH_W + LINE_AW;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int DELAY_W    = 17;
  localparam int FB_W       = 15;
  localparam int WET_W      = 16;
  localparam int GAIN_W     = 17;  // wet / dry gains after clamping, 0 .. 32768
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WET      = 2'd2;

  // Register reset values
  localparam logic [DELAY_W-1:0] DELAY_RST = 17'd24000;
  localparam logic [FB_W-1:0]    FB_RST    = 15'd16384;
  localparam logic [WET_W-1:0]   WET_RST   = 16'd16384;

  // Unity gain in unsigned Q2.15
  localparam logic [GAIN_W-1:0]  GAIN_ONE  = 17'd32768;

  typedef logic [LINE_AW-1:0]         line_idx_t;
  typedef logic [MEM_AW-1:0]          mem_addr_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic    channel;
    sample_t sample_in;
    logic    block_end;
  } in_item_t;

  typedef struct packed {
    sample_t sample_out;
    logic    channel_out;
    logic    block_end_out;
  } out_item_t;

  // Item held in the read stage, waiting on line data
  typedef struct packed {
    mem_addr_t waddr;
    logic      rd_valid;   // entry was written at least once
    logic      fwd;        // take data from the last write, not from the line
    logic      channel;
    sample_t   sample;
    logic      block_end;
  } s1_t;

endpackage

// File: rtl/core/fde_line_mem.sv
module fde_line_mem (
  input  logic               clk,
  input  logic               re,
  input  fde_pkg::mem_addr_t raddr,
  input  logic               we,
  input  fde_pkg::mem_addr_t waddr,
  input  fde_pkg::sample_t   wdata,
  output fde_pkg::sample_t   rdata_r
);

  localparam int Depth = 1 << fde_pkg::MEM_AW;

  fde_pkg::sample_t mem [0:Depth-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/fde_ctrl.sv
module fde_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  fde_pkg::in_item_t   in_data,
  input  logic                accept,
  input  logic                adv,
  input  fde_pkg::line_idx_t  delay,
  output fde_pkg::mem_addr_t  raddr,
  output logic                hazard,
  output logic                fwd,
  output logic                s1_valid,
  output fde_pkg::s1_t        s1_stage,
  output logic                s2_valid,
  output fde_pkg::mem_addr_t  s2_waddr
);

  localparam int LineAw = fde_pkg::LINE_AW;
  localparam int ChW    = fde_pkg::CH_W;
  localparam int Chans  = fde_pkg::CHANNELS;
  localparam int Depth  = fde_pkg::LINE_DEPTH;

  fde_pkg::line_idx_t widx_r [Chans];
  logic [Chans-1:0]   wrap_r;

  logic               s1_v_r;
  fde_pkg::s1_t       s1_r;
  logic               s2_v_r;
  fde_pkg::mem_addr_t s2_waddr_r;

  logic [ChW-1:0]     line_ch;
  fde_pkg::line_idx_t wp, rp, wp_nxt;
  logic               wp_last, rd_valid;
  fde_pkg::mem_addr_t waddr;

  always_comb begin
    if (int'(in_data.channel) >= Chans) begin
      line_ch = ChW'(Chans - 1);
    end else begin
      line_ch = ChW'(in_data.channel);
    end
    wp = widx_r[line_ch];
    if (wp >= delay) begin
      rp = wp - delay;
    end else begin
      rp = LineAw'(int'(wp) + Depth - int'(delay));
    end
    // before the first wrap only [0, wp) has been written
    rd_valid = wrap_r[line_ch] || (rp < wp);
    wp_last  = (wp == LineAw'(Depth - 1));
    wp_nxt   = wp_last ? '0 : wp + LineAw'(1);
    raddr    = {line_ch, rp};
    waddr    = {line_ch, wp};
    hazard   = s1_v_r && (s1_r.waddr == raddr);
    fwd      = s2_v_r && (s2_waddr_r == raddr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Chans; i++) begin
        widx_r[i] <= '0;
      end
      wrap_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (accept) begin
        widx_r[line_ch] <= wp_nxt;
        if (wp_last) begin
          wrap_r[line_ch] <= 1'b1;
        end
      end
      if (adv) begin
        s1_v_r <= accept;
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.waddr     <= waddr;
      s1_r.rd_valid  <= rd_valid;
      s1_r.fwd       <= fwd;
      s1_r.channel   <= in_data.channel;
      s1_r.sample    <= in_data.sample_in;
      s1_r.block_end <= in_data.block_end;
    end
    if (adv) begin
      s2_waddr_r <= s1_r.waddr;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_stage = s1_r;
  assign s2_valid = s2_v_r;
  assign s2_waddr = s2_waddr_r;

endmodule

// File: rtl/core/fde_mix.sv
module fde_mix (
  input  logic                                clk,
  input  logic                                adv,
  input  fde_pkg::s1_t                        s1_stage,
  input  fde_pkg::sample_t                    rdata,
  input  logic [fde_pkg::FB_W-1:0]            fb_gain,
  input  logic [fde_pkg::GAIN_W-1:0]          wet_gain,
  input  logic [fde_pkg::GAIN_W-1:0]          dry_gain,
  output fde_pkg::sample_t                    line,
  output fde_pkg::out_item_t                  out_item
);

  function automatic fde_pkg::sample_t sat19(input logic signed [18:0] v);
    fde_pkg::sample_t r;
    if (v > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  fde_pkg::sample_t   delayed;
  fde_pkg::sample_t   lw_line_r;

  logic signed [30:0] d31, fb31, pfb;
  logic signed [32:0] x33, d33, dry33, wet33, pdry, pwet;

  logic signed [30:0] s2_pfb_r;
  logic signed [32:0] s2_pdry_r, s2_pwet_r;
  fde_pkg::sample_t   s2_x_r;
  logic               s2_ch_r, s2_be_r;

  logic signed [31:0] fb_rnd;
  logic signed [16:0] fb_q;
  logic signed [18:0] line_sum;
  logic signed [33:0] mix_sum;
  logic signed [18:0] mix_q;

  // read stage: pick the delayed sample, form the three products
  always_comb begin
    if (s1_stage.fwd) begin
      delayed = lw_line_r;
    end else if (s1_stage.rd_valid) begin
      delayed = rdata;
    end else begin
      delayed = '0;
    end
    d31   = {{15{delayed[15]}}, delayed};
    fb31  = {16'b0, fb_gain};
    pfb   = d31 * fb31;
    x33   = {{17{s1_stage.sample[15]}}, s1_stage.sample};
    d33   = {{17{delayed[15]}}, delayed};
    dry33 = {16'b0, dry_gain};
    wet33 = {16'b0, wet_gain};
    pdry  = x33 * dry33;
    pwet  = d33 * wet33;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pfb_r  <= pfb;
      s2_pdry_r <= pdry;
      s2_pwet_r <= pwet;
      s2_x_r    <= s1_stage.sample;
      s2_ch_r   <= s1_stage.channel;
      s2_be_r   <= s1_stage.block_end;
      lw_line_r <= line;
    end
  end

  // finish stage: round half up, saturate
  always_comb begin
    fb_rnd   = {s2_pfb_r[30], s2_pfb_r} + 32'sd16384;
    fb_q     = fb_rnd[31:15];
    line_sum = {{3{s2_x_r[15]}}, s2_x_r} + {{2{fb_q[16]}}, fb_q};
    line     = sat19(line_sum);
    mix_sum  = {s2_pdry_r[32], s2_pdry_r} + {s2_pwet_r[32], s2_pwet_r} + 34'sd16384;
    mix_q    = mix_sum[33:15];
    out_item.sample_out    = sat19(mix_q);
    out_item.channel_out   = s2_ch_r;
    out_item.block_end_out = s2_be_r;
  end

endmodule

// File: rtl/core/feedback_delay_echo.sv
// Channel  Dir  Handshake              Payload
// in_      in   in_valid / in_stall    in_item_t: channel, sample_in, block_end
// out_     out  out_valid / out_stall  out_item_t: sample_out, channel_out, block_end_out
// cfg_     in   cfg_we                 cfg_index, cfg_wdata (17 bits)
//
// One transfer per cycle unless a stall or line hazard holds the input; each item passes
// the read stage, finish stage and output register. Back-to-back transfers on one channel
// with a one-sample delay: the second waits while the first is in the read stage, since
// the line read-modify-write loop spans the read and finish stages. Reset: no clearing
// pass; a per-channel write pointer plus wrap flag make unwritten entries read as zero.
// Stalls: out_stall with a held result freezes the whole pipeline and raises in_stall.
module feedback_delay_echo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fde_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fde_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [fde_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fde_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int LineAw = fde_pkg::LINE_AW;
  localparam int Depth  = fde_pkg::LINE_DEPTH;

  // configuration
  logic [fde_pkg::DELAY_W-1:0] delay_r;
  logic [fde_pkg::FB_W-1:0]    fb_r;
  logic [fde_pkg::WET_W-1:0]   wet_r;

  fde_pkg::line_idx_t          delay_lim;
  logic [fde_pkg::GAIN_W-1:0]  wet_gain, dry_gain;

  // pipeline control
  logic                        adv, accept, hazard, fwd;
  logic                        s1_valid, s2_valid;
  fde_pkg::s1_t                s1_stage;
  fde_pkg::mem_addr_t          raddr, s2_waddr;
  fde_pkg::sample_t            rdata, line;
  fde_pkg::out_item_t          mix_out;

  logic                        out_valid_r;
  fde_pkg::out_item_t          out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= fde_pkg::DELAY_RST;
      fb_r    <= fde_pkg::FB_RST;
      wet_r   <= fde_pkg::WET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fde_pkg::CFG_DELAY:    delay_r <= cfg_wdata[fde_pkg::DELAY_W-1:0];
        fde_pkg::CFG_FEEDBACK: fb_r    <= cfg_wdata[fde_pkg::FB_W-1:0];
        fde_pkg::CFG_WET:      wet_r   <= cfg_wdata[fde_pkg::WET_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // zero delay acts as one; too long a delay clamps to the line length minus one
  always_comb begin
    if (delay_r == '0) begin
      delay_lim = LineAw'(1);
    end else if (32'(delay_r) >= 32'(Depth)) begin
      delay_lim = LineAw'(Depth - 1);
    end else begin
      delay_lim = LineAw'(delay_r);
    end
    if ({1'b0, wet_r} > fde_pkg::GAIN_ONE) begin
      wet_gain = fde_pkg::GAIN_ONE;
    end else begin
      wet_gain = {1'b0, wet_r};
    end
    dry_gain = fde_pkg::GAIN_ONE - wet_gain;
  end

  // whole pipeline moves together whenever the output slot is free or being taken
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv || hazard;
  assign accept   = in_valid && !in_stall;

  fde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .accept   (accept),
    .adv      (adv),
    .delay    (delay_lim),
    .raddr    (raddr),
    .hazard   (hazard),
    .fwd      (fwd),
    .s1_valid (s1_valid),
    .s1_stage (s1_stage),
    .s2_valid (s2_valid),
    .s2_waddr (s2_waddr)
  );

  // read at transfer, write back when the finish stage retires
  fde_line_mem u_mem (
    .clk     (clk),
    .re      (accept),
    .raddr   (raddr),
    .we      (adv && s2_valid),
    .waddr   (s2_waddr),
    .wdata   (line),
    .rdata_r (rdata)
  );

  fde_mix u_mix (
    .clk      (clk),
    .adv      (adv),
    .s1_stage (s1_stage),
    .rdata    (rdata),
    .fb_gain  (fb_r),
    .wet_gain (wet_gain),
    .dry_gain (dry_gain),
    .line     (line),
    .out_item (mix_out)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= mix_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // accepted item never reads the entry the item right ahead of it still has to write
  a_no_raw_gap: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !(s2_valid && (s2_waddr == $past(raddr))))
    else $error("line read overlaps pending write");

  // forwarding needs a retiring write to take data from
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    accept && fwd |-> s2_valid)
    else $error("forward without a write in flight");

  // held result blocks new input
  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> in_stall)
    else $error("input taken while output held");

  // stalled read stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && !adv |=> s1_valid && $stable(s1_stage.waddr))
    else $error("read stage item lost in stall");
`endif

endmodule
